>>> hdl/lthbr_pkg.sv
// Package for the blend ramp tracker: slot entry type, table sizes,
// register indexes and state codes. Used by every module of the block.
`default_nettype none
package lthbr_pkg;
   localparam int SLOTS = 256;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int ID_W = 32;
   localparam int DIST_W = 16;
   localparam int BLEND_W = 13;
   localparam int STAMP_W = 32;
   localparam int CSR_W = 16;
   localparam logic [BLEND_W-1:0] BLEND_ONE = 13'd4096;

   localparam logic [1:0] REG_LOD_DISTANCE = 2'd0;
   localparam logic [1:0] REG_HYST_BAND = 2'd1;
   localparam logic [1:0] REG_BLEND_STEP = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]    obj;
      logic [BLEND_W-1:0] blend;
      logic               proxy;
      logic               moving;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_WRITE,
      ST_SEND
   } state_type;
endpackage
`default_nettype wire

>>> hdl/lthbr_cell.sv
// One slot of the rotating table: holds an entry and passes it to the next
// cell on each shift. Depends on lthbr_pkg.
`default_nettype none
module lthbr_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift_en,
   input  wire lthbr_pkg::slot_type d,
   output lthbr_pkg::slot_type     q
);
   logic                valid_ff;
   lthbr_pkg::slot_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= d;
      end
   end

   // A cell never loaded since reset reads as an empty slot.
   assign q = valid_ff ? data_ff : '0;
endmodule
`default_nettype wire

>>> hdl/lru_tracked_hysteresis_blend_ramp_core.sv
// Level-of-detail crossfade tracker with an LRU slot table held in a ring of
// cells. Depends on lthbr_pkg and lthbr_cell.
// A valid word goes through a full rotation of the ring to search, a compute state, a full
// rotation to write back, a state that loads the result once the previous result has been
// taken, and then the handshake that hands it over. An invalid word or a zero id skips the
// search and the write-back and answers with a cleared entry. One word at a time.
// Reset (synchronous, active high) empties all slots and restores the registers.
`default_nettype none
module lru_tracked_hysteresis_blend_ramp_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // object_id[31:0], distance[47:32]
   input  wire logic        req_tuser,   // request_valid
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // blend_level[12:0], zero[15:13]
   output logic             rsp_tuser,   // proxy_side
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [15:0] csr_wdata
);
   localparam int N = lthbr_pkg::SLOTS;
   localparam int SB = lthbr_pkg::SLOT_BITS;
   localparam int BW = lthbr_pkg::BLEND_W;

   lthbr_pkg::state_type state_ff, state_in;
   logic [15:0]  lod_ff, band_ff;
   logic [BW-1:0] step_ff;
   logic [31:0]  id_ff, id_in;
   logic [15:0]  dist_ff, dist_in;
   logic [SB-1:0] cnt_ff, cnt_in, pick_ff, pick_in;
   logic          stop_ff, stop_in, found_ff, found_in;
   logic [31:0]  min_ff, min_in;
   lthbr_pkg::slot_type pent_ff, pent_in, new_ff, new_in;
   logic [31:0]  use_ff, use_in;
   logic          rvalid_ff, rvalid_in;
   logic [BW-1:0] rblend_ff, rblend_in;
   logic          rside_ff, rside_in;
   logic          shift_en;
   logic          req_acc;
   lthbr_pkg::slot_type cell_d [N];
   lthbr_pkg::slot_type cell_q [N];
   lthbr_pkg::slot_type head;
   lthbr_pkg::slot_type e;
   logic [16:0]  hi_edge, lo_edge;
   logic [BW:0]  sum;

   assign head = cell_q[N-1];
   assign shift_en = (state_ff == lthbr_pkg::ST_SCAN) || (state_ff == lthbr_pkg::ST_WRITE);

   // Ring: slot k sits at the head after k shifts of a pass.
   always_comb begin
      cell_d[0] = head;
      if (state_ff == lthbr_pkg::ST_WRITE && cnt_ff == pick_ff) begin
         cell_d[0] = new_ff;
      end
      for (int i = 1; i < N; i++) begin
         cell_d[i] = cell_q[i-1];
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cell
      lthbr_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift_en(shift_en),
         .d       (cell_d[g]),
         .q       (cell_q[g])
      );
   end

   assign req_tready = (state_ff == lthbr_pkg::ST_IDLE);
   assign req_acc = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lod_ff <= 16'd538;
         band_ff <= 16'd24;
         step_ff <= 13'd348;
      end else if (csr_we) begin
         unique case (csr_addr)
            lthbr_pkg::REG_LOD_DISTANCE: lod_ff <= csr_wdata;
            lthbr_pkg::REG_HYST_BAND:    band_ff <= csr_wdata;
            lthbr_pkg::REG_BLEND_STEP:   step_ff <= csr_wdata[BW-1:0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lthbr_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser && req_tdata[31:0] != 32'd0) state_in = lthbr_pkg::ST_SCAN;
               else state_in = lthbr_pkg::ST_SEND;
            end
         end
         lthbr_pkg::ST_SCAN: if (cnt_ff == SB'(N-1)) state_in = lthbr_pkg::ST_CALC;
         lthbr_pkg::ST_CALC: state_in = lthbr_pkg::ST_WRITE;
         lthbr_pkg::ST_WRITE: if (cnt_ff == SB'(N-1)) state_in = lthbr_pkg::ST_SEND;
         lthbr_pkg::ST_SEND: if (!rvalid_ff || rsp_tready) state_in = lthbr_pkg::ST_IDLE;
         default: state_in = lthbr_pkg::ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      id_in = id_ff;
      dist_in = dist_ff;
      cnt_in = cnt_ff;
      pick_in = pick_ff;
      stop_in = stop_ff;
      found_in = found_ff;
      min_in = min_ff;
      pent_in = pent_ff;
      new_in = new_ff;
      use_in = use_ff;
      rvalid_in = rvalid_ff;
      rblend_in = rblend_ff;
      rside_in = rside_ff;
      e = pent_ff;
      hi_edge = {1'b0, lod_ff} + {1'b0, band_ff};
      lo_edge = {1'b0, dist_ff} + {1'b0, band_ff};
      sum = '0;
      if (rvalid_ff && rsp_tready) rvalid_in = 1'b0;
      unique case (state_ff)
         lthbr_pkg::ST_IDLE: begin
            if (req_acc) begin
               id_in = req_tdata[31:0];
               dist_in = req_tdata[47:32];
               cnt_in = '0;
               stop_in = 1'b0;
               found_in = 1'b0;
               pick_in = '0;
               // An invalid word answers with this cleared entry.
               new_in = '0;
            end
         end
         lthbr_pkg::ST_SCAN: begin
            cnt_in = cnt_ff + SB'(1);
            if (!stop_ff) begin
               if (head.obj == id_ff) begin
                  pick_in = cnt_ff;
                  pent_in = head;
                  found_in = 1'b1;
                  stop_in = 1'b1;
               end else if (head.obj == 32'd0) begin
                  pick_in = cnt_ff;
                  stop_in = 1'b1;
               end else if (cnt_ff == '0 || head.stamp < min_ff) begin
                  pick_in = cnt_ff;
                  min_in = head.stamp;
               end
            end
         end
         lthbr_pkg::ST_CALC: begin
            if (!found_ff) begin
               e.obj = id_ff;
               e.proxy = (dist_ff >= lod_ff);
               e.blend = e.proxy ? lthbr_pkg::BLEND_ONE : '0;
               e.moving = 1'b0;
            end
            use_in = use_ff + 32'd1;
            e.stamp = use_in;
            if (!e.moving) begin
               if (!e.proxy && {1'b0, dist_ff} > hi_edge) begin
                  e.proxy = 1'b1;
                  e.moving = 1'b1;
               end else if (e.proxy && lo_edge < {1'b0, lod_ff}) begin
                  e.proxy = 1'b0;
                  e.moving = 1'b1;
               end
            end
            if (e.moving) begin
               if (e.proxy && e.blend < lthbr_pkg::BLEND_ONE) begin
                  sum = {1'b0, e.blend} + {1'b0, step_ff};
                  e.blend = (sum > {1'b0, lthbr_pkg::BLEND_ONE}) ? lthbr_pkg::BLEND_ONE
                                                                 : sum[BW-1:0];
               end else if (e.proxy) begin
                  sum = {1'b0, e.blend} - {1'b0, lthbr_pkg::BLEND_ONE};
                  e.blend = (sum > {1'b0, step_ff}) ? e.blend - step_ff
                                                   : lthbr_pkg::BLEND_ONE;
               end else begin
                  e.blend = (e.blend > step_ff) ? e.blend - step_ff : '0;
               end
               if (e.blend == (e.proxy ? lthbr_pkg::BLEND_ONE : '0)) e.moving = 1'b0;
            end
            new_in = e;
            cnt_in = '0;
         end
         lthbr_pkg::ST_WRITE: cnt_in = cnt_ff + SB'(1);
         lthbr_pkg::ST_SEND: begin
            // The result registers change only once the previous word has gone.
            if (!rvalid_ff || rsp_tready) begin
               rvalid_in = 1'b1;
               rblend_in = new_ff.blend;
               rside_in = new_ff.proxy;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lthbr_pkg::ST_IDLE;
         use_ff <= '0;
         rvalid_ff <= 1'b0;
         cnt_ff <= '0;
         stop_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         use_ff <= use_in;
         rvalid_ff <= rvalid_in;
         cnt_ff <= cnt_in;
         stop_ff <= stop_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      dist_ff <= dist_in;
      pick_ff <= pick_in;
      min_ff <= min_in;
      pent_ff <= pent_in;
      new_ff <= new_in;
      rblend_ff <= rblend_in;
      rside_ff <= rside_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata = {3'b000, rblend_ff};
   assign rsp_tuser = rside_ff;

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lthbr_pkg::ST_SCAN && cnt_ff == SB'(N-1)) |=> state_ff == lthbr_pkg::ST_CALC)
      else $error("scan pass did not end after a full rotation");
   a_found_stops: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> stop_ff)
      else $error("hit recorded without stopping the search");
   a_write_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lthbr_pkg::ST_WRITE && cnt_ff == pick_ff) |=> cell_q[0].obj == $past(new_ff.obj))
      else $error("updated entry not written into the ring");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("word accepted while a previous one is in progress");
endmodule
`default_nettype wire
